// ===== rtl/core/rhsv_pkg.sv =====
`default_nettype none

package rhsv_pkg;

    localparam int CH_W           = 8;
    localparam int QUO_W          = 8;
    localparam int DIVIDEND_W     = 17;
    localparam int DIVISOR_W      = CH_W + 1;
    localparam int NUM_W          = CH_W + 3;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

    localparam int HUE_SCALE = 85;
    localparam int SAT_SCALE = 510;

    typedef struct packed {
        logic [DIVIDEND_W-1:0] rem;
        logic [DIVISOR_W-1:0]  den;
        logic [QUO_W-1:0]      quo;
    } t_div_stage;

endpackage

`default_nettype wire

// ===== rtl/core/rhsv_if.sv =====
`default_nettype none

interface rhsv_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [rhsv_pkg::CH_W-1:0]  blue;
    logic [rhsv_pkg::CH_W-1:0]  green;
    logic [rhsv_pkg::CH_W-1:0]  red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface rhsv_hsv_if;
    logic                       valid;
    logic                       ready;
    logic [rhsv_pkg::CH_W-1:0]  hue;
    logic [rhsv_pkg::CH_W-1:0]  saturation;
    logic [rhsv_pkg::CH_W-1:0]  brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rhsv_div.sv =====
`default_nettype none

module rhsv_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic [rhsv_pkg::DIVIDEND_W-1:0]   i_num,
    input  wire logic [rhsv_pkg::DIVISOR_W-1:0]    i_den,
    output logic      [rhsv_pkg::QUO_W-1:0]        o_quo
);
    import rhsv_pkg::*;

    t_div_stage r_stg    [DIV_STAGES];
    t_div_stage w_stg_in [DIV_STAGES];
    t_div_stage n_stg    [DIV_STAGES];

    assign w_stg_in[0] = '{rem: i_num, den: i_den, quo: '0};

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        if (k > 0) begin : g_link
            assign w_stg_in[k] = r_stg[k-1];
        end

        always_comb begin
            logic [DIVIDEND_W-1:0] cmp;
            int                    sh;
            n_stg[k] = w_stg_in[k];
            for (int j = 0; j < BITS_PER_STAGE; j++) begin
                sh  = QUO_W - 1 - k * BITS_PER_STAGE - j;
                cmp = DIVIDEND_W'(n_stg[k].den) << sh;
                if (n_stg[k].rem >= cmp) begin
                    n_stg[k].rem = n_stg[k].rem - cmp;
                    n_stg[k].quo = n_stg[k].quo | (QUO_W'(1) << sh);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_quo = r_stg[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

// ===== rtl/core/rgb_to_hsv_8bit_core.sv =====
// RGB to HSV converter, 8-bit channels, hue over the full 0..255 circle.
// Input channel i_pix carries one blue/green/red pixel per transfer; output
// channel o_hsv carries hue, saturation and brightness, one result per pixel,
// in input order. Both use a valid/ready handshake.
// Throughput: one pixel per clock while o_hsv.ready is high.
// Pipeline: two stages find max/min, sector and the divide operands; the two
// divides (saturation and hue) run in parallel restoring dividers of 4 stages,
// 2 quotient bits each. The last divider stage is the output register.
// When the receiver stalls the whole pipeline holds and i_pix.ready drops
// in the same cycle; no data is lost or repeated.
// Reset clears all valid bits; the block accepts pixels as soon as reset is
// released.
`default_nettype none

module rgb_to_hsv_8bit_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rhsv_pixel_if.sink  i_pix,
    rhsv_hsv_if.source  o_hsv
);
    import rhsv_pkg::*;

    localparam int LAT = DIV_STAGES + 2;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    logic                         w_ce;
    logic [LAT-1:0]               r_vld;

    logic [CH_W-1:0]              w_mx;
    logic [CH_W-1:0]              w_mn;
    logic signed [CH_W:0]         w_diff;
    t_sector                      w_sec;

    logic [CH_W-1:0]              r_a_mx;
    logic [CH_W-1:0]              r_a_delta;
    logic signed [CH_W:0]         r_a_diff;
    t_sector                      r_a_sec;

    logic signed [NUM_W:0]        w_num_s;
    logic signed [NUM_W:0]        w_num_w;
    logic [NUM_W-1:0]             w_num;
    logic [DIVIDEND_W-1:0]        n_b_hnum;
    logic [DIVIDEND_W-1:0]        n_b_snum;
    logic [DIVISOR_W-1:0]         n_b_hden;
    logic [DIVISOR_W-1:0]         n_b_sden;

    logic [DIVIDEND_W-1:0]        r_b_hnum;
    logic [DIVIDEND_W-1:0]        r_b_snum;
    logic [DIVISOR_W-1:0]         r_b_hden;
    logic [DIVISOR_W-1:0]         r_b_sden;
    logic [CH_W-1:0]              r_b_mx;

    logic [CH_W-1:0]              r_mx_d [DIV_STAGES];
    logic [QUO_W-1:0]             w_hue;
    logic [QUO_W-1:0]             w_sat;

    assign w_ce        = !r_vld[LAT-1] || o_hsv.ready;
    assign i_pix.ready = w_ce;

    always_comb begin
        w_mn = i_pix.red;
        if (i_pix.green < w_mn) begin
            w_mn = i_pix.green;
        end
        if (i_pix.blue < w_mn) begin
            w_mn = i_pix.blue;
        end
        if (i_pix.red >= i_pix.green && i_pix.red >= i_pix.blue) begin
            w_sec  = SEC_RED;
            w_mx   = i_pix.red;
            w_diff = $signed({1'b0, i_pix.green}) - $signed({1'b0, i_pix.blue});
        end else if (i_pix.green >= i_pix.blue) begin
            w_sec  = SEC_GREEN;
            w_mx   = i_pix.green;
            w_diff = $signed({1'b0, i_pix.blue}) - $signed({1'b0, i_pix.red});
        end else begin
            w_sec  = SEC_BLUE;
            w_mx   = i_pix.blue;
            w_diff = $signed({1'b0, i_pix.red}) - $signed({1'b0, i_pix.green});
        end
    end

    always_comb begin
        case (r_a_sec)
            SEC_GREEN: w_num_s = $signed({2'b0, r_a_delta, 1'b0});
            SEC_BLUE:  w_num_s = $signed({1'b0, r_a_delta, 2'b0});
            default:   w_num_s = '0;
        endcase
        w_num_s = w_num_s + (NUM_W+1)'(r_a_diff);
        w_num_w = w_num_s;
        if (w_num_s < 0) begin
            w_num_w = w_num_s + $signed({1'b0, r_a_delta, 2'b0})
                              + $signed({2'b0, r_a_delta, 1'b0});
        end
        w_num    = w_num_w[NUM_W-1:0];
        n_b_hnum = DIVIDEND_W'(w_num) * DIVIDEND_W'(HUE_SCALE) + DIVIDEND_W'(r_a_delta);
        n_b_snum = DIVIDEND_W'(r_a_delta) * DIVIDEND_W'(SAT_SCALE) + DIVIDEND_W'(r_a_mx);
        n_b_hden = (r_a_delta == '0) ? DIVISOR_W'(1) : {r_a_delta, 1'b0};
        n_b_sden = (r_a_mx == '0)    ? DIVISOR_W'(1) : {r_a_mx, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[LAT-2:0], i_pix.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a_mx    <= w_mx;
            r_a_delta <= w_mx - w_mn;
            r_a_diff  <= w_diff;
            r_a_sec   <= w_sec;
            r_b_hnum  <= n_b_hnum;
            r_b_snum  <= n_b_snum;
            r_b_hden  <= n_b_hden;
            r_b_sden  <= n_b_sden;
            r_b_mx    <= r_a_mx;
            r_mx_d[0] <= r_b_mx;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_mx_d[k] <= r_mx_d[k-1];
            end
        end
    end

    rhsv_div u_hue_div (
        .i_clk (i_clk),
        .i_en  (w_ce),
        .i_num (r_b_hnum),
        .i_den (r_b_hden),
        .o_quo (w_hue)
    );

    rhsv_div u_sat_div (
        .i_clk (i_clk),
        .i_en  (w_ce),
        .i_num (r_b_snum),
        .i_den (r_b_sden),
        .o_quo (w_sat)
    );

    assign o_hsv.valid      = r_vld[LAT-1];
    assign o_hsv.hue        = w_hue;
    assign o_hsv.saturation = w_sat;
    assign o_hsv.brightness = r_mx_d[DIV_STAGES-1];

endmodule

`default_nettype wire
